FILE: rtl/sldf_pkg.sv
// shared types, constants and helper functions of the sync and length deframer
`default_nettype none
package sldf_pkg;

   localparam logic [7:0]  SYNC_FIRST       = 8'h44;
   localparam logic [7:0]  SYNC_SECOND      = 8'h46;
   localparam logic [4:0]  FOLD_BLOCK       = 5'd20;
   localparam logic [7:0]  FOLD_MOD         = 8'hFF;
   localparam logic [16:0] HEADER_AND_CHECK = 17'd12;
   localparam logic [16:0] LENGTH_DONE      = 17'd10;
   localparam logic [15:0] ACK_MASK_RESET   = 16'h8000;

   // input opcodes
   localparam logic OP_BYTE   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // packet status codes
   localparam logic [1:0] ST_VALID     = 2'd0;
   localparam logic [1:0] ST_CHECKSUM  = 2'd1;
   localparam logic [1:0] ST_FRAMING   = 2'd2;
   localparam logic [1:0] ST_TRUNCATED = 2'd3;

   // running fletcher sums
   typedef struct packed {
      logic [15:0] sum_low;
      logic [15:0] sum_high;
      logic [4:0]  block_pos;
   } fletch_type;

   // state of the packet candidate being collected
   typedef struct packed {
      logic [16:0] bytes_seen;
      logic [16:0] expected_total;
      logic        framing_seen;
      logic [31:0] packet_id;
      logic [15:0] message_type;
      logic [15:0] payload_length;
      fletch_type  sums;
      logic [15:0] trailing_word;
   } cand_type;

   // one result item
   typedef struct packed {
      logic [1:0]  packet_status;
      logic        has_header;
      logic [31:0] id_word;
      logic [15:0] type_word;
      logic [15:0] length_word;
      logic        response_flag;
      logic        type_known;
      logic [15:0] check_word;
      logic [16:0] total_bytes;
   } result_type;

   // residue mod 255 of a 16-bit value, using 256 = 1 mod 255
   function automatic logic [15:0] mod255(input logic [15:0] x);
      logic [8:0] s;
      logic [8:0] t;
      s = {1'b0, x[15:8]} + {1'b0, x[7:0]};
      t = {8'd0, s[8]} + {1'b0, s[7:0]};
      if (t[7:0] == FOLD_MOD) begin
         mod255 = 16'd0;
      end else begin
         mod255 = {8'd0, t[7:0]};
      end
   endfunction

   // table of known message codes
   function automatic logic type_is_known(input logic [15:0] t);
      type_is_known =
         (t == 16'h0001) ||
         (t >= 16'h0020 && t <= 16'h0023) ||
         (t >= 16'h0030 && t <= 16'h003A) ||
         (t >= 16'h0100 && t <= 16'h0104) ||
         (t >= 16'h0110 && t <= 16'h0116) ||
         (t == 16'h0120) ||
         (t >= 16'h0200 && t <= 16'h0203) ||
         (t >= 16'h0205 && t <= 16'h0207);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/sldf_fletcher.sv
// fletcher-16 style sum update for one byte, folded mod 255 every block
`default_nettype none
module sldf_fletcher (
   input  wire sldf_pkg::fletch_type sums_old,
   input  wire logic [7:0]           byte_value,
   output sldf_pkg::fletch_type      sums_new,
   output logic                      sum_ok
);

   logic [15:0] low_add;
   logic [15:0] high_add;
   logic [4:0]  pos_add;

   // plain running sums
   always_comb begin
      low_add  = sums_old.sum_low + {8'd0, byte_value};
      high_add = sums_old.sum_high + low_add;
      pos_add  = sums_old.block_pos + 5'd1;
   end

   // fold at the end of each block
   always_comb begin
      if (pos_add >= sldf_pkg::FOLD_BLOCK) begin
         sums_new.sum_low   = sldf_pkg::mod255(low_add);
         sums_new.sum_high  = sldf_pkg::mod255(high_add);
         sums_new.block_pos = 5'd0;
      end else begin
         sums_new.sum_low   = low_add;
         sums_new.sum_high  = high_add;
         sums_new.block_pos = pos_add;
      end
   end

   // whole packet check: both sums fold to zero
   assign sum_ok = (sldf_pkg::mod255(sums_new.sum_low) == 16'd0) &&
                   (sldf_pkg::mod255(sums_new.sum_high) == 16'd0);

endmodule
`default_nettype wire

FILE: rtl/sync_length_deframer_fletcher.sv
// top level: sync hunt, header capture, length tracking and packet reporting
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tdata: byte_value; tuser: opcode, byte_framing_error
//  rsp      out  rsp_tvalid/tready    tuser: packet_status; tdata: header, check, count
//  csr      in   csr_valid/csr_ready  csr_data: ack_flag_mask
//
// one item per cycle while req_tready is high: each accepted item updates the candidate
// state register, and a result is loaded into the output register in that same cycle.
// the output register holds a result until rsp_tready; req_tready stays high
// while the output register is empty or being emptied.
// synchronous reset clears the candidate, the output valid and sets the mask.
`default_nettype none
module sync_length_deframer_fletcher (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] byte_value
   input  wire logic [1:0]   req_tuser,   // [0] opcode, [1] byte_framing_error
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [0] has_header, [32:1] id_word, [48:33] type_word, [64:49] length_word,
   // [65] response_flag, [66] type_known, [82:67] check_word,
   // [99:83] total_bytes, [103:100] zero
   output logic [103:0]      rsp_tdata,
   output logic [1:0]        rsp_tuser,   // [1:0] packet_status
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [15:0]  csr_data
);

   sldf_pkg::cand_type   cand_ff;
   sldf_pkg::cand_type   cand_in;
   sldf_pkg::cand_type   grown;
   sldf_pkg::result_type rsp_ff;
   sldf_pkg::result_type rsp_in;
   sldf_pkg::fletch_type sums_next;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [15:0]          ack_mask_ff;
   logic [15:0]          ack_mask_in;
   logic                 req_fire;
   logic                 sum_ok;
   logic                 emit;
   logic                 truncated;
   logic                 opcode;
   logic                 fe;
   logic [7:0]           b;
   sldf_pkg::cand_type   src;
   logic                 hdr;

   assign opcode   = req_tuser[0];
   assign fe       = req_tuser[1];
   assign b        = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   sldf_fletcher u_fletcher (
      .sums_old   (cand_ff.sums),
      .byte_value (b),
      .sums_new   (sums_next),
      .sum_ok     (sum_ok)
   );

   // candidate after taking one more byte past the sync pair
   always_comb begin
      grown = cand_ff;
      case (cand_ff.bytes_seen)
         17'd2: grown.packet_id[7:0]       = b;
         17'd3: grown.packet_id[15:8]      = b;
         17'd4: grown.packet_id[23:16]     = b;
         17'd5: grown.packet_id[31:24]     = b;
         17'd6: grown.message_type[7:0]    = b;
         17'd7: grown.message_type[15:8]   = b;
         17'd8: grown.payload_length[7:0]  = b;
         17'd9: grown.payload_length[15:8] = b;
         default: ;
      endcase
      grown.sums          = sums_next;
      grown.framing_seen  = cand_ff.framing_seen | fe;
      grown.trailing_word = {b, cand_ff.trailing_word[15:8]};
      grown.bytes_seen    = cand_ff.bytes_seen + 17'd1;
      if (grown.bytes_seen == sldf_pkg::LENGTH_DONE) begin
         grown.expected_total = sldf_pkg::HEADER_AND_CHECK + {1'b0, grown.payload_length};
      end
   end

   // candidate state machine for one accepted item
   always_comb begin
      cand_in   = cand_ff;
      emit      = 1'b0;
      truncated = 1'b0;
      src       = cand_ff;
      if (req_fire) begin
         if (opcode == sldf_pkg::OP_FINISH) begin
            if (cand_ff.bytes_seen != 17'd0) begin
               emit      = 1'b1;
               truncated = 1'b1;
            end
            cand_in = '0;
         end else if (cand_ff.bytes_seen == 17'd0) begin
            if (b == sldf_pkg::SYNC_FIRST) begin
               cand_in.framing_seen  = fe;
               cand_in.sums          = sums_next;
               cand_in.trailing_word = {b, 8'd0};
               cand_in.bytes_seen    = 17'd1;
            end
         end else if (cand_ff.bytes_seen == 17'd1 && b != sldf_pkg::SYNC_SECOND) begin
            // a second 'D' restarts the hunt on itself
            if (b == sldf_pkg::SYNC_FIRST) begin
               cand_in.framing_seen = fe;
            end else begin
               cand_in = '0;
            end
         end else begin
            src = grown;
            if (grown.expected_total != 17'd0 &&
                grown.bytes_seen >= grown.expected_total) begin
               emit    = 1'b1;
               cand_in = '0;
            end else begin
               cand_in = grown;
            end
         end
      end
   end

   // result item built from the candidate it closes
   always_comb begin
      hdr = src.bytes_seen >= sldf_pkg::HEADER_AND_CHECK;
      if (truncated) begin
         rsp_in.packet_status = sldf_pkg::ST_TRUNCATED;
      end else if (src.framing_seen) begin
         rsp_in.packet_status = sldf_pkg::ST_FRAMING;
      end else if (sum_ok) begin
         rsp_in.packet_status = sldf_pkg::ST_VALID;
      end else begin
         rsp_in.packet_status = sldf_pkg::ST_CHECKSUM;
      end
      rsp_in.has_header    = hdr;
      rsp_in.id_word       = hdr ? src.packet_id : 32'd0;
      rsp_in.type_word     = hdr ? src.message_type : 16'd0;
      rsp_in.length_word   = hdr ? src.payload_length : 16'd0;
      rsp_in.response_flag = hdr && ((src.message_type & ack_mask_ff) != 16'd0);
      rsp_in.type_known    = hdr &&
                             sldf_pkg::type_is_known(src.message_type & ~ack_mask_ff);
      rsp_in.check_word    = truncated ? 16'd0 : src.trailing_word;
      rsp_in.total_bytes   = src.bytes_seen;
   end

   // output register valid
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // configuration register
   assign ack_mask_in = (csr_valid && csr_ready) ? csr_data : ack_mask_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         ack_mask_ff  <= sldf_pkg::ACK_MASK_RESET;
      end else begin
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
         ack_mask_ff  <= ack_mask_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.packet_status;
   assign rsp_tdata  = {4'd0, rsp_ff.total_bytes, rsp_ff.check_word, rsp_ff.type_known,
                        rsp_ff.response_flag, rsp_ff.length_word, rsp_ff.type_word,
                        rsp_ff.id_word, rsp_ff.has_header};

endmodule
`default_nettype wire
